@@ src/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge, off while reset is high
`define ASSERT_CLKD(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/ssv_pkg.sv @@
package ssv_pkg;

   // header layout
   localparam int HEADER_BYTES_DEFAULT = 20;
   localparam int MAGIC_LEN            = 8;
   localparam logic [24:0] POS_VERSION = 25'd8;
   localparam logic [24:0] POS_HLEN    = 25'd10;
   localparam logic [24:0] POS_PLEN    = 25'd12;
   localparam logic [24:0] POS_CRC     = 25'd16;

   localparam logic [7:0] MAGIC_BYTES [MAGIC_LEN] = '{
      8'h50, 8'h41, 8'h54, 8'h4D, 8'h53, 8'h4E, 8'h41, 8'h50
   };

   // reflected crc-32
   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

   // stream phases
   localparam logic [1:0] PH_HEADER  = 2'd0;
   localparam logic [1:0] PH_PAYLOAD = 2'd1;
   localparam logic [1:0] PH_DISCARD = 2'd2;

   // verdicts
   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_IO           = 3'd1;
   localparam logic [2:0] ST_NOT_SNAPSHOT = 3'd2;
   localparam logic [2:0] ST_NEWER        = 3'd3;
   localparam logic [2:0] ST_CRC          = 3'd4;

   // register map
   localparam logic CSR_EXPECTED_VERSION = 1'b0;
   localparam logic CSR_PAYLOAD_LENGTH   = 1'b1;

   localparam logic [15:0] EXPECTED_VERSION_RESET = 16'd1;
   localparam logic [23:0] PAYLOAD_LENGTH_RESET   = 24'd65536;

endpackage

@@ src/ssv_crc_byte.sv @@
module ssv_crc_byte (
   input  logic [31:0] crc_cur,
   input  logic [7:0]  data_byte,
   output logic [31:0] crc_next
);

   // eight bit steps of the reflected crc, unrolled
   always_comb begin
      logic [31:0] c;
      c = crc_cur ^ {24'd0, data_byte};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (ssv_pkg::CRC_POLY & {32{c[0]}});
      end
      crc_next = c;
   end

endmodule

@@ src/snapshot_stream_verifier.sv @@
// snapshot stream verifier
// req channel: one stream byte per beat (req_data_byte) with req_end_of_stream
//   marking the last byte the source can deliver.
// rsp channel: at most one verdict beat per stream, rsp_status with
//   rsp_computed_crc (inverted crc-32 over the payload bytes seen).
// csr port: index 0 expected version, index 1 payload length; write only
//   while no stream is in flight.
// the header is judged on its last byte; then the configured number of
// payload bytes runs through the crc, and the verdict comes on the last one.
// bytes after a verdict are dropped until end of stream, which restarts.
// throughput: one byte per cycle while no verdict is stalled, set by the
//   combinational eight-bit crc update feeding the crc register.
// a verdict is registered and is on rsp in the cycle after the byte that causes it.
// when the receiver stalls, the verdict holds in the output register and
//   req_ready falls until it is taken.
// reset (synchronous): stream state cleared, registers to their defaults,
//   no verdict pending.
`include "assert_macros.svh"

module snapshot_stream_verifier #(
   parameter int HEADER_BYTES = ssv_pkg::HEADER_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_stream,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_computed_crc,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [23:0] csr_write_data
);

   logic [15:0] exp_version_ff, exp_version_in;
   logic [23:0] pay_len_ff, pay_len_in;
   logic [24:0] pos_ff, pos_in;
   logic [1:0]  phase_ff, phase_in;
   logic [31:0] crc_ff, crc_in;
   logic        magic_ok_ff, magic_ok_in;
   logic [15:0] hdr_version_ff, hdr_version_in;
   logic [15:0] hdr_length_ff, hdr_length_in;
   logic [31:0] hdr_payload_ff, hdr_payload_in;
   logic [31:0] stored_crc_ff, stored_crc_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_crc_ff, rsp_crc_in;

   logic        accept;
   logic [31:0] crc_upd;
   logic [24:0] pay_count;
   logic        emit;
   logic [2:0]  emit_status;

   assign req_ready        = !rsp_valid_ff || rsp_ready;
   assign accept           = req_valid && req_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_computed_crc = rsp_crc_ff;
   assign pay_count        = pos_ff + 25'd1;

   ssv_crc_byte u_crc (
      .crc_cur   (crc_ff),
      .data_byte (req_data_byte),
      .crc_next  (crc_upd)
   );

   // configuration writes
   always_comb begin
      exp_version_in = exp_version_ff;
      pay_len_in     = pay_len_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            ssv_pkg::CSR_EXPECTED_VERSION: exp_version_in = csr_write_data[15:0];
            ssv_pkg::CSR_PAYLOAD_LENGTH:   pay_len_in     = csr_write_data;
         endcase
      end
   end

   // per-byte stream logic
   always_comb begin
      pos_in         = pos_ff;
      phase_in       = phase_ff;
      crc_in         = crc_ff;
      magic_ok_in    = magic_ok_ff;
      hdr_version_in = hdr_version_ff;
      hdr_length_in  = hdr_length_ff;
      hdr_payload_in = hdr_payload_ff;
      stored_crc_in  = stored_crc_ff;
      emit           = 1'b0;
      emit_status    = ssv_pkg::ST_OK;

      if (accept) begin
         unique case (phase_ff)
            ssv_pkg::PH_HEADER: begin
               // capture header fields
               if (pos_ff < 25'(ssv_pkg::MAGIC_LEN)) begin
                  if (req_data_byte != ssv_pkg::MAGIC_BYTES[pos_ff[2:0]]) begin
                     magic_ok_in = 1'b0;
                  end
               end else begin
                  unique case (pos_ff)
                     ssv_pkg::POS_VERSION:         hdr_version_in[7:0]    = req_data_byte;
                     ssv_pkg::POS_VERSION + 25'd1: hdr_version_in[15:8]   = req_data_byte;
                     ssv_pkg::POS_HLEN:            hdr_length_in[7:0]     = req_data_byte;
                     ssv_pkg::POS_HLEN + 25'd1:    hdr_length_in[15:8]    = req_data_byte;
                     ssv_pkg::POS_PLEN:            hdr_payload_in[7:0]    = req_data_byte;
                     ssv_pkg::POS_PLEN + 25'd1:    hdr_payload_in[15:8]   = req_data_byte;
                     ssv_pkg::POS_PLEN + 25'd2:    hdr_payload_in[23:16]  = req_data_byte;
                     ssv_pkg::POS_PLEN + 25'd3:    hdr_payload_in[31:24]  = req_data_byte;
                     ssv_pkg::POS_CRC:             stored_crc_in[7:0]     = req_data_byte;
                     ssv_pkg::POS_CRC + 25'd1:     stored_crc_in[15:8]    = req_data_byte;
                     ssv_pkg::POS_CRC + 25'd2:     stored_crc_in[23:16]   = req_data_byte;
                     ssv_pkg::POS_CRC + 25'd3:     stored_crc_in[31:24]   = req_data_byte;
                     default: ;
                  endcase
               end
               // judge on the last header byte
               if (pos_ff >= 25'(HEADER_BYTES - 1)) begin
                  if (!magic_ok_in) begin
                     emit        = 1'b1;
                     emit_status = ssv_pkg::ST_NOT_SNAPSHOT;
                  end else if (hdr_version_in > exp_version_ff) begin
                     emit        = 1'b1;
                     emit_status = ssv_pkg::ST_NEWER;
                  end else if (hdr_version_in != exp_version_ff ||
                               hdr_length_in != 16'(HEADER_BYTES) ||
                               hdr_payload_in != {8'd0, pay_len_ff}) begin
                     emit        = 1'b1;
                     emit_status = ssv_pkg::ST_NOT_SNAPSHOT;
                  end else if (pay_len_ff == 24'd0) begin
                     emit        = 1'b1;
                     emit_status = (~crc_ff == stored_crc_in) ? ssv_pkg::ST_OK
                                                              : ssv_pkg::ST_CRC;
                  end else if (req_end_of_stream) begin
                     emit        = 1'b1;
                     emit_status = ssv_pkg::ST_IO;
                  end else begin
                     phase_in = ssv_pkg::PH_PAYLOAD;
                     pos_in   = 25'd0;
                  end
               end else begin
                  pos_in = pay_count;
                  if (req_end_of_stream) begin
                     emit        = 1'b1;
                     emit_status = ssv_pkg::ST_IO;
                  end
               end
            end
            ssv_pkg::PH_PAYLOAD: begin
               crc_in = crc_upd;
               pos_in = pay_count;
               if (pay_count >= {1'b0, pay_len_ff}) begin
                  emit        = 1'b1;
                  emit_status = (~crc_upd == stored_crc_ff) ? ssv_pkg::ST_OK
                                                            : ssv_pkg::ST_CRC;
               end else if (req_end_of_stream) begin
                  emit        = 1'b1;
                  emit_status = ssv_pkg::ST_IO;
               end
            end
            default: ;
         endcase
         if (emit) begin
            phase_in = ssv_pkg::PH_DISCARD;
         end
      end

      // result register, loaded before any restart clears the crc
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_crc_in    = rsp_crc_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = emit_status;
         rsp_crc_in    = ~crc_in;
      end else if (rsp_ready) begin
         rsp_valid_in  = 1'b0;
      end

      // end of stream restarts
      if (accept && req_end_of_stream) begin
         pos_in         = 25'd0;
         phase_in       = ssv_pkg::PH_HEADER;
         crc_in         = ssv_pkg::CRC_INIT;
         magic_ok_in    = 1'b1;
         hdr_version_in = 16'd0;
         hdr_length_in  = 16'd0;
         hdr_payload_in = 32'd0;
         stored_crc_in  = 32'd0;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_version_ff <= ssv_pkg::EXPECTED_VERSION_RESET;
         pay_len_ff     <= ssv_pkg::PAYLOAD_LENGTH_RESET;
         pos_ff         <= 25'd0;
         phase_ff       <= ssv_pkg::PH_HEADER;
         crc_ff         <= ssv_pkg::CRC_INIT;
         magic_ok_ff    <= 1'b1;
         hdr_version_ff <= 16'd0;
         hdr_length_ff  <= 16'd0;
         hdr_payload_ff <= 32'd0;
         stored_crc_ff  <= 32'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         exp_version_ff <= exp_version_in;
         pay_len_ff     <= pay_len_in;
         pos_ff         <= pos_in;
         phase_ff       <= phase_in;
         crc_ff         <= crc_in;
         magic_ok_ff    <= magic_ok_in;
         hdr_version_ff <= hdr_version_in;
         hdr_length_ff  <= hdr_length_in;
         hdr_payload_ff <= hdr_payload_in;
         stored_crc_ff  <= stored_crc_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_crc_ff    <= rsp_crc_in;
   end

   // checks
   `ASSERT_CLKD(a_stall_blocks_input, clock, reset,
      rsp_valid_ff && !rsp_ready |-> !req_ready, "input taken while verdict stalled")
   `ASSERT_CLKD(a_status_legal, clock, reset,
      rsp_valid_ff |-> rsp_status_ff <= ssv_pkg::ST_CRC, "verdict code out of range")
   `ASSERT_CLKD(a_eos_restarts, clock, reset,
      accept && req_end_of_stream |=> phase_ff == ssv_pkg::PH_HEADER && pos_ff == 25'd0,
      "end of stream did not restart")
   `ASSERT_CLKD(a_header_crc_idle, clock, reset,
      phase_ff == ssv_pkg::PH_HEADER |-> crc_ff == ssv_pkg::CRC_INIT,
      "crc moved during header")
   `ASSERT_CLK(a_reset_clears_rsp, clock,
      reset |=> !rsp_valid_ff, "verdict pending after reset")

endmodule

@@ bench/snapshot_stream_verifier_tb.sv @@
module snapshot_stream_verifier_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HDR          = ssv_pkg::HEADER_BYTES_DEFAULT;
   localparam int P_VER        = int'(ssv_pkg::POS_VERSION);
   localparam int P_HLEN       = int'(ssv_pkg::POS_HLEN);
   localparam int P_PLEN       = int'(ssv_pkg::POS_PLEN);
   localparam int P_CRC        = int'(ssv_pkg::POS_CRC);
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 4;
   localparam int LIMIT_CYCLES = 400000;
   localparam int PHASE_BYTES  = 220;

   typedef logic [7:0] byte_q_type[$];

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] crc;
   } verdict_type;

   typedef enum {
      SK_GOOD, SK_BAD_CRC, SK_SHORT_PAYLOAD, SK_SHORT_HEADER, SK_BAD_MAGIC,
      SK_NEWER, SK_OLDER, SK_BAD_HLEN, SK_BAD_PLEN, SK_NOISE
   } stream_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_end_of_stream = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_computed_crc;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = 1'b0;
   logic [23:0] csr_write_data = 24'h0;

   // predictor copy of the registers and the stream state
   logic [15:0] cfg_version;
   logic [23:0] cfg_plen;
   logic [24:0] byte_count;
   logic [1:0]  stream_phase;
   logic [31:0] crc_reg;
   logic        magic_ok;
   logic [15:0] hdr_version;
   logic [15:0] hdr_len;
   logic [31:0] hdr_plen;
   logic [31:0] hdr_crc;

   verdict_type pending_verdicts[$];
   int          error_count = 0;
   int          bytes_sent = 0;
   int          cycle_count = 0;

   // sender and receiver pacing
   int          burst_left = 0;
   logic        sender_gaps = 1'b1;
   logic        rsp_stalls = 1'b1;
   logic        hold_toggle = 1'b0;
   logic        hold_seen = 1'b0;
   int          hold_left = 0;
   int          stall_left = 0;
   int          run_left = 0;

   snapshot_stream_verifier dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_end_of_stream(req_end_of_stream),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_computed_crc (rsp_computed_crc),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // reflected crc-32, one byte, bit serial
   function automatic logic [31:0] crc32_update(logic [31:0] c, logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'h0, b};
      for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ ssv_pkg::CRC_POLY) : (r >> 1);
      return r;
   endfunction

   function automatic logic [31:0] crc32_of(byte_q_type p);
      logic [31:0] c;
      c = ssv_pkg::CRC_INIT;
      foreach (p[i]) c = crc32_update(c, p[i]);
      return ~c;
   endfunction

   function automatic logic [2:0] crc_verdict();
      return (~crc_reg == hdr_crc) ? ssv_pkg::ST_OK : ssv_pkg::ST_CRC;
   endfunction

   function automatic byte_q_type make_header(logic [15:0] ver, logic [15:0] hlen,
                                              logic [31:0] plen, logic [31:0] crc);
      byte_q_type h;
      for (int i = 0; i < ssv_pkg::MAGIC_LEN; i++) h.push_back(ssv_pkg::MAGIC_BYTES[3'(i)]);
      for (int i = 0; i < 2; i++) h.push_back(ver[8*i +: 8]);
      for (int i = 0; i < 2; i++) h.push_back(hlen[8*i +: 8]);
      for (int i = 0; i < 4; i++) h.push_back(plen[8*i +: 8]);
      for (int i = 0; i < 4; i++) h.push_back(crc[8*i +: 8]);
      while (h.size() < HDR) h.push_back(8'h00);
      return h;
   endfunction

   task automatic restart_stream();
      byte_count   = '0;
      stream_phase = ssv_pkg::PH_HEADER;
      crc_reg      = ssv_pkg::CRC_INIT;
      magic_ok     = 1'b1;
      hdr_version  = '0;
      hdr_len      = '0;
      hdr_plen     = '0;
      hdr_crc      = '0;
   endtask

   task automatic push_verdict(input logic [2:0] status);
      verdict_type v;
      v.status = status;
      v.crc    = ~crc_reg;
      pending_verdicts.push_back(v);
      stream_phase = ssv_pkg::PH_DISCARD;
   endtask

   // expected verdict for one accepted byte
   task automatic predict_byte(input logic [7:0] b, input logic eos);
      int pos;
      pos = int'(byte_count);
      if (stream_phase == ssv_pkg::PH_HEADER) begin
         if (pos < ssv_pkg::MAGIC_LEN) begin
            if (b != ssv_pkg::MAGIC_BYTES[pos[2:0]]) magic_ok = 1'b0;
         end else if (pos < P_HLEN) begin
            hdr_version[8*(pos-P_VER) +: 8] = b;
         end else if (pos < P_PLEN) begin
            hdr_len[8*(pos-P_HLEN) +: 8] = b;
         end else if (pos < P_CRC) begin
            hdr_plen[8*(pos-P_PLEN) +: 8] = b;
         end else if (pos < P_CRC + 4) begin
            hdr_crc[8*(pos-P_CRC) +: 8] = b;
         end
         if (pos + 1 >= HDR) begin
            // header judged on its last byte
            if (!magic_ok) push_verdict(ssv_pkg::ST_NOT_SNAPSHOT);
            else if (hdr_version > cfg_version) push_verdict(ssv_pkg::ST_NEWER);
            else if (hdr_version != cfg_version || hdr_len != 16'(HDR) ||
                     hdr_plen != {8'h00, cfg_plen}) push_verdict(ssv_pkg::ST_NOT_SNAPSHOT);
            else if (cfg_plen == '0) push_verdict(crc_verdict());
            else if (eos) push_verdict(ssv_pkg::ST_IO);
            else begin
               stream_phase = ssv_pkg::PH_PAYLOAD;
               byte_count   = '0;
            end
         end else begin
            byte_count = byte_count + 25'd1;
            if (eos) push_verdict(ssv_pkg::ST_IO);
         end
      end else if (stream_phase == ssv_pkg::PH_PAYLOAD) begin
         crc_reg    = crc32_update(crc_reg, b);
         byte_count = byte_count + 25'd1;
         if (byte_count >= {1'b0, cfg_plen}) push_verdict(crc_verdict());
         else if (eos) push_verdict(ssv_pkg::ST_IO);
      end
      if (eos) restart_stream();
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on %s: got %0h, expected %0h at cycle %0d",
               what, got, want, cycle_count);
      error_count++;
   endtask

   // one beat on the req channel, with bursts and gaps
   task automatic send_byte(input logic [7:0] b, input logic eos);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (sender_gaps) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid         <= 1'b1;
      req_data_byte     <= b;
      req_end_of_stream <= eos;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_byte(b, eos);
      bytes_sent++;
   endtask

   task automatic send_stream(input byte_q_type s);
      for (int i = 0; i < s.size(); i++) send_byte(s[i], i == s.size() - 1);
   endtask

   // wait until every verdict is in and the block has settled
   task automatic drain_block();
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [15:0] ver, input logic [23:0] plen);
      drain_block();
      csr_write_enable <= 1'b1;
      csr_index        <= ssv_pkg::CSR_EXPECTED_VERSION;
      csr_write_data   <= {8'($urandom_range(0, 255)), ver};
      @(posedge clock);
      cfg_version = ver;
      csr_index      <= ssv_pkg::CSR_PAYLOAD_LENGTH;
      csr_write_data <= plen;
      @(posedge clock);
      cfg_plen = plen;
      csr_write_enable <= 1'b0;
   endtask

   // register defaults: passing header, then the stream stops inside the payload
   task automatic test_default_config();
      byte_q_type s;
      s = make_header(16'd1, 16'(HDR), 32'h0001_0000, 32'h1234_5678);
      s.push_back(8'hFF);
      s.push_back(8'h00);
      s.push_back(8'hA5);
      send_stream(s);
   endtask

   task automatic test_header_checks();
      byte_q_type s;
      set_config(16'd1, 24'd2);
      // wrong magic, stream ends on the last header byte
      s = make_header(16'd1, 16'(HDR), 32'd2, 32'h0);
      s[0] = 8'h00;
      send_stream(s);
      // newer version, trailing bytes dropped
      s = make_header(16'd2, 16'(HDR), 32'd2, 32'h0);
      s.push_back(8'h11);
      s.push_back(8'h22);
      send_stream(s);
      // older version
      s = make_header(16'd0, 16'(HDR), 32'd2, 32'h0);
      send_stream(s);
      // wrong header length
      s = make_header(16'd1, 16'(HDR + 1), 32'd2, 32'h0);
      send_stream(s);
      // payload field differs only above the register width
      s = make_header(16'd1, 16'(HDR), 32'h0100_0002, 32'h0);
      send_stream(s);
      // early end on the first byte and in mid header
      s = make_header(16'd1, 16'(HDR), 32'd2, 32'h0);
      while (s.size() > 1) void'(s.pop_back());
      send_stream(s);
      s = make_header(16'd1, 16'(HDR), 32'd2, 32'h0);
      while (s.size() > 10) void'(s.pop_back());
      send_stream(s);
      // passing header that ends on its last byte: payload missing
      s = make_header(16'd1, 16'(HDR), 32'd2, 32'h0);
      send_stream(s);
   endtask

   task automatic test_payload_checks();
      byte_q_type s;
      byte_q_type p;
      set_config(16'd1, 24'd2);
      p = {8'h00, 8'hFF};
      // crc match, then a discarded tail
      s = make_header(16'd1, 16'(HDR), 32'd2, crc32_of(p));
      foreach (p[i]) s.push_back(p[i]);
      s.push_back(8'h5A);
      s.push_back(8'hC3);
      send_stream(s);
      // crc mismatch with end of stream on the verdict byte
      s = make_header(16'd1, 16'(HDR), 32'd2, ~crc32_of(p));
      foreach (p[i]) s.push_back(p[i]);
      send_stream(s);
      // early end inside the payload
      s = make_header(16'd1, 16'(HDR), 32'd2, crc32_of(p));
      s.push_back(8'h80);
      send_stream(s);
   endtask

   // zero payload length: verdict on the last header byte against crc 0
   task automatic test_zero_payload();
      byte_q_type s;
      set_config(16'd1, 24'd0);
      s = make_header(16'd1, 16'(HDR), 32'd0, 32'h0);
      send_stream(s);
      s = make_header(16'd1, 16'(HDR), 32'd0, 32'h0000_0001);
      s.push_back(8'h77);
      send_stream(s);
   endtask

   task automatic test_config_extremes();
      byte_q_type s;
      set_config(16'hFFFF, 24'hFF_FFFF);
      s = make_header(16'hFFFF, 16'(HDR), 32'h00FF_FFFF, 32'h0);
      repeat (4) s.push_back(8'($urandom));
      send_stream(s);
      s = make_header(16'h0000, 16'(HDR), 32'h00FF_FFFF, 32'h0);
      send_stream(s);
      set_config(16'h0000, 24'd1);
      s = make_header(16'h0001, 16'(HDR), 32'd1, 32'h0);
      send_stream(s);
      s = make_header(16'h0000, 16'(HDR), 32'd1, crc32_of('{8'h3C}));
      s.push_back(8'h3C);
      send_stream(s);
   endtask

   // receiver holds off while short failing streams keep coming
   task automatic test_backpressure();
      byte_q_type s;
      set_config(16'd1, 24'd2);
      sender_gaps = 1'b0;
      hold_toggle <= ~hold_toggle;
      repeat (4) begin
         s = make_header(16'd1, 16'(HDR), 32'd2, 32'h0);
         s[3] = 8'h00;
         send_stream(s);
      end
      sender_gaps = 1'b1;
   endtask

   task automatic send_random_stream();
      byte_q_type      s;
      byte_q_type      payload;
      stream_kind_type kind;
      int              r;
      int              n;
      logic [15:0]     ver;
      logic [15:0]     hlen;
      logic [31:0]     plen;
      logic [31:0]     crc;
      r = $urandom_range(0, 99);
      if (r < 45) kind = SK_GOOD;
      else if (r < 57) kind = SK_BAD_CRC;
      else if (r < 67) kind = SK_SHORT_PAYLOAD;
      else if (r < 72) kind = SK_SHORT_HEADER;
      else if (r < 78) kind = SK_BAD_MAGIC;
      else if (r < 83) kind = SK_NEWER;
      else if (r < 88) kind = SK_OLDER;
      else if (r < 92) kind = SK_BAD_HLEN;
      else if (r < 96) kind = SK_BAD_PLEN;
      else kind = SK_NOISE;

      ver  = cfg_version;
      hlen = 16'(HDR);
      plen = {8'h00, cfg_plen};
      repeat (int'(cfg_plen)) payload.push_back(8'($urandom));
      crc = crc32_of(payload);
      case (kind)
         SK_BAD_CRC:  crc = crc ^ (32'd1 << $urandom_range(0, 31));
         SK_NEWER:    ver = ver + 16'($urandom_range(1, 3));
         SK_OLDER:    ver = ver - 16'($urandom_range(1, 3));
         SK_BAD_HLEN: hlen = hlen ^ 16'($urandom_range(1, 65535));
         SK_BAD_PLEN: begin
            if ($urandom_range(0, 1) == 1) plen = plen ^ (32'($urandom_range(1, 255)) << 24);
            else plen = plen ^ 32'($urandom_range(1, 7));
         end
         default: ;
      endcase
      s = make_header(ver, hlen, plen, crc);

      if (kind == SK_BAD_MAGIC) begin
         n = $urandom_range(0, ssv_pkg::MAGIC_LEN - 1);
         s[n] = s[n] ^ 8'($urandom_range(1, 255));
      end
      if (kind == SK_SHORT_HEADER) begin
         n = $urandom_range(1, HDR - 1);
         while (s.size() > n) void'(s.pop_back());
      end else if (kind == SK_NOISE) begin
         s = {};
         repeat ($urandom_range(1, 30)) s.push_back(8'($urandom));
      end else begin
         if (kind == SK_SHORT_PAYLOAD && payload.size() > 0) n = $urandom_range(0, payload.size() - 1);
         else n = payload.size();
         for (int i = 0; i < n; i++) s.push_back(payload[i]);
         if (kind != SK_SHORT_PAYLOAD) repeat ($urandom_range(0, 3)) s.push_back(8'($urandom));
      end
      sender_gaps = ($urandom_range(0, 3) != 0);
      send_stream(s);
   endtask

   task automatic test_random_streams();
      int target;
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: set_config(16'd1, 24'd16);
            1: set_config(16'h0000, 24'd1);
            2: set_config(16'hFFFF, 24'd24);
            3: set_config(16'($urandom_range(0, 65535)), 24'($urandom_range(2, 40)));
            4: set_config(16'($urandom_range(0, 65535)), 24'd0);
            default: set_config(16'($urandom_range(0, 65535)), 24'($urandom_range(1, 8)));
         endcase
         // in phase 1 the receiver never stalls; the sender still takes its random gaps
         rsp_stalls <= (p != 1);
         target = bytes_sent + PHASE_BYTES;
         while (bytes_sent < target) begin
            send_random_stream();
            if (p == 1) sender_gaps = 1'b0;
         end
      end
   endtask

   // receiver: ready runs, short stalls, and a long hold on request
   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen = hold_toggle;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (run_left != 0) begin
         run_left--;
         rsp_ready <= 1'b1;
      end else begin
         run_left   = $urandom_range(1, 16);
         stall_left = rsp_stalls ? $urandom_range(1, 8) : 0;
         rsp_ready <= 1'b1;
      end
   end

   // compare each verdict beat with the oldest pending one
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_verdicts.size() == 0) begin
            report_mismatch("verdict with nothing pending, status", {29'h0, rsp_status}, 32'h0);
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", {29'h0, rsp_status}, {29'h0, want.status});
            if (rsp_computed_crc !== want.crc)
               report_mismatch("computed_crc", rsp_computed_crc, want.crc);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout with %0d verdicts pending", pending_verdicts.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      cfg_version = ssv_pkg::EXPECTED_VERSION_RESET;
      cfg_plen    = ssv_pkg::PAYLOAD_LENGTH_RESET;
      restart_stream();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_default_config();
      test_header_checks();
      test_payload_checks();
      test_zero_payload();
      test_config_extremes();
      test_backpressure();
      test_random_streams();

      drain_block();
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+src
src/ssv_pkg.sv
src/ssv_crc_byte.sv
src/snapshot_stream_verifier.sv
bench/snapshot_stream_verifier_tb.sv
